FILE: hw/rtl/idt_pkg.sv
package idt_pkg;

    // Channel count and counter width
    localparam int NUM_INPUTS  = 4;
    localparam int COUNT_WIDTH = 16;

    // Port field widths
    localparam int RAW_W    = 4;
    localparam int THR_W    = 16;
    localparam int HOLD_W   = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Width used when comparing a counter against a threshold
    localparam int CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TICKS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TICKS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF_TICKS = 2'd3;

    // Reset values of the registers
    localparam logic [THR_W-1:0]  RST_ON_TICKS  = 16'd20;
    localparam logic [THR_W-1:0]  RST_OFF_TICKS = 16'd20;
    localparam logic [HOLD_W-1:0] RST_HOLDOFF   = 8'd30;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    // Switching thresholds shared by all channels
    typedef struct packed {
        logic [THR_W-1:0] on_ticks;
        logic [THR_W-1:0] off_ticks;
    } t_thresholds;

    // Per-channel result of one tick
    typedef struct packed {
        logic level;
        logic change;
    } t_chan_status;

endpackage

FILE: hw/rtl/idt_channel.sv
module idt_channel
    import idt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_act,
    input  t_thresholds i_thr,
    output t_chan_status o_status
);

    localparam t_count COUNT_MAX = '1;

    logic   r_level;
    t_count r_active_cnt;
    t_count r_inactive_cnt;

    logic   n_level;
    t_count n_active_cnt;
    t_count n_inactive_cnt;

    t_count     run_cnt;
    t_count     run_inc;
    logic [CMP_W-1:0] run_cmp;
    logic [CMP_W-1:0] inc_cmp;
    logic [CMP_W-1:0] thr_cmp;
    logic       run_ok;
    logic       run_hit;

    // Pick the counter and threshold of the direction being qualified
    always_comb begin
        run_cnt = r_level ? r_inactive_cnt : r_active_cnt;
        thr_cmp = CMP_W'(r_level ? i_thr.off_ticks : i_thr.on_ticks);
        run_cmp = CMP_W'(run_cnt);
        run_inc = run_cnt + t_count'(1);
        inc_cmp = CMP_W'(run_inc);
        run_ok  = (run_cmp < thr_cmp) && (run_cnt != COUNT_MAX);
        run_hit = run_ok && (inc_cmp == thr_cmp);
    end

    // Advance or clear the counters and switch the level
    always_comb begin
        n_level        = r_level;
        n_active_cnt   = r_active_cnt;
        n_inactive_cnt = r_inactive_cnt;
        if (!r_level) begin
            if (i_act) begin
                if (run_ok) begin
                    n_active_cnt = run_inc;
                end
                if (run_hit) begin
                    n_level = 1'b1;
                end
            end else begin
                n_active_cnt = '0;
            end
        end else begin
            if (!i_act) begin
                if (run_ok) begin
                    n_inactive_cnt = run_inc;
                end
                if (run_hit) begin
                    n_level = 1'b0;
                end
            end else begin
                n_inactive_cnt = '0;
            end
        end
        // Clear the opposite counter on a switch
        if (n_level != r_level) begin
            if (n_level) begin
                n_inactive_cnt = '0;
            end else begin
                n_active_cnt = '0;
            end
        end
    end

    assign o_status.level  = n_level;
    assign o_status.change = n_level != r_level;

    // Hold the channel state between beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level        <= 1'b0;
            r_active_cnt   <= '0;
            r_inactive_cnt <= '0;
        end else if (i_step) begin
            r_level        <= n_level;
            r_active_cnt   <= n_active_cnt;
            r_inactive_cnt <= n_inactive_cnt;
        end
    end

endmodule

FILE: hw/rtl/input_debounce_with_trigger_core.sv
// Each beat accepted at the input passes an input register and then a result register,
// with one tick of counter and compare logic for all channels between them; one beat
// per cycle is taken while the result is not stalled.
// Reset (synchronous, active low) clears all channel counters and levels, loads the
// thresholds with 20 ticks, polarity normal, and the trigger holdoff count with 30.
module input_debounce_with_trigger_core
    import idt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration writes
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // Input beats
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [RAW_W-1:0]     i_raw_levels,
    // Result beats
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [RAW_W-1:0]     o_qualified_levels,
    output logic [RAW_W-1:0]     o_trigger_pulses,
    output logic                 o_holdoff_active
);

    t_thresholds            r_thr;
    logic                   r_invert;
    logic [HOLD_W-1:0]      r_holdoff_cnt;

    logic                   r_in_valid;
    logic [RAW_W-1:0]       r_raw;

    logic                   r_out_valid;
    logic [RAW_W-1:0]       r_qual;
    logic [RAW_W-1:0]       r_trig;
    logic                   r_masked;

    logic                   step;
    logic                   masked;
    logic [NUM_INPUTS-1:0]  act;
    t_chan_status           status [NUM_INPUTS];
    logic [RAW_W-1:0]       n_qual;
    logic [RAW_W-1:0]       n_trig;

    // Move a beat from the input register into the result register
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;
    assign masked     = r_holdoff_cnt != '0;

    // Configuration registers; a holdoff write also reloads the count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.on_ticks  <= RST_ON_TICKS;
            r_thr.off_ticks <= RST_OFF_TICKS;
            r_invert        <= 1'b0;
            r_holdoff_cnt   <= RST_HOLDOFF;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_ON_TICKS:      r_thr.on_ticks  <= i_cfg_data[THR_W-1:0];
                    CFG_OFF_TICKS:     r_thr.off_ticks <= i_cfg_data[THR_W-1:0];
                    CFG_INVERT:        r_invert        <= i_cfg_data[0];
                    CFG_HOLDOFF_TICKS: r_holdoff_cnt   <= i_cfg_data[HOLD_W-1:0];
                    default: begin
                    end
                endcase
            end else if (step && masked) begin
                r_holdoff_cnt <= r_holdoff_cnt - HOLD_W'(1);
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_raw <= i_raw_levels;
        end
    end

    // One debounce cell per channel
    for (genvar g = 0; g < NUM_INPUTS; g++) begin : g_chan
        if (g < RAW_W) begin : g_pin
            assign act[g] = r_raw[g] ^ r_invert;
        end else begin : g_nopin
            assign act[g] = r_invert;
        end

        idt_channel u_channel (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_step   (step),
            .i_act    (act[g]),
            .i_thr    (r_thr),
            .o_status (status[g])
        );
    end

    // Gather levels and unmasked triggers of the low channels
    always_comb begin
        n_qual = '0;
        n_trig = '0;
        for (int b = 0; b < RAW_W; b++) begin
            if (b < NUM_INPUTS) begin
                n_qual[b] = status[b].level;
                n_trig[b] = status[b].change && !masked;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_qual   <= n_qual;
            r_trig   <= n_trig;
            r_masked <= masked;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_qualified_levels = r_qual;
    assign o_trigger_pulses   = r_trig;
    assign o_holdoff_active   = r_masked;

`ifndef SYNTHESIS
    // No trigger leaves during holdoff
    a_masked_no_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_holdoff_active) |-> (o_trigger_pulses == '0))
        else $error("trigger pulse during holdoff");

    // Expired holdoff stays expired unless rewritten
    a_holdoff_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_holdoff_cnt == '0 && !i_cfg_wr_en) |=> (r_holdoff_cnt == '0))
        else $error("holdoff count left zero without a write");

    // Holdoff count moves down by one per beat while masking
    a_holdoff_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && masked && !i_cfg_wr_en) |=> (r_holdoff_cnt == $past(r_holdoff_cnt) - 8'd1))
        else $error("holdoff count did not step");

    // A stalled result keeps the input beat waiting
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |=> (r_in_valid && $stable(r_raw)))
        else $error("input beat lost while result stalled");
`endif

endmodule
